[src/sbc_pkg.sv]
// shared constants, types and helpers of the sprite blitter
`timescale 1ns / 1ps
package sbc_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int OWNER_BITS  = 16;
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int PIX_W       = 2;
    localparam int ENTRY_W     = OWNER_BITS + PIX_W;
    localparam int HIT_W       = 17;
    localparam int APB_AW      = 5;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;
    localparam logic [8:0] FRAME_W_MAX  = 9'(MAX_WIDTH);
    localparam logic [8:0] FRAME_H_MAX  = 9'(MAX_HEIGHT);
    localparam logic [8:0] SPRITE_W_MAX = 9'd256;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_THREE = 8'h33;
    localparam logic [7:0] RAW_THREE  = 8'd3;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_command;

    localparam logic [2:0] REG_FRAME_W = 3'd0;
    localparam logic [2:0] REG_FRAME_H = 3'd1;
    localparam logic [2:0] REG_PAL_0   = 3'd2;
    localparam logic [2:0] REG_PAL_1   = 3'd3;
    localparam logic [2:0] REG_PAL_2   = 3'd4;
    localparam logic [2:0] REG_PAL_3   = 3'd5;

    localparam logic RESULT_BLIT = 1'b0;
    localparam logic RESULT_READ = 1'b1;

    typedef struct packed {
        logic capture;
        logic calc;
        logic addr;
        logic update;
        logic clr_step;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic needs_result;
    } t_dp_stat;

    function automatic logic [8:0] clamp9(input logic [8:0] v, input logic [8:0] hi);
        logic [8:0] r;
        r = v;
        if (v == 9'd0) r = 9'd1;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

[src/sbc_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps
module sbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sbc_regs.sv]
// apb configuration registers: frame size and palette
`timescale 1ns / 1ps
module sbc_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sbc_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [8:0]                o_frame_w,
    output logic [8:0]                o_frame_h,
    output logic [23:0]               o_pal [4]
);

    logic [8:0]  r_frame_w;
    logic [8:0]  r_frame_h;
    logic [23:0] r_pal [4];
    logic        wr;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr      = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= sbc_pkg::FRAME_W_MAX;
            r_frame_h <= sbc_pkg::FRAME_H_MAX;
            for (int i = 0; i < 4; i++) r_pal[i] <= '0;
        end else if (wr) begin
            unique case (reg_idx)
                sbc_pkg::REG_FRAME_W: r_frame_w <= pwdata[8:0];
                sbc_pkg::REG_FRAME_H: r_frame_h <= pwdata[8:0];
                sbc_pkg::REG_PAL_0:   r_pal[0]  <= pwdata[23:0];
                sbc_pkg::REG_PAL_1:   r_pal[1]  <= pwdata[23:0];
                sbc_pkg::REG_PAL_2:   r_pal[2]  <= pwdata[23:0];
                sbc_pkg::REG_PAL_3:   r_pal[3]  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sbc_pkg::REG_FRAME_W: prdata = {23'd0, r_frame_w};
            sbc_pkg::REG_FRAME_H: prdata = {23'd0, r_frame_h};
            sbc_pkg::REG_PAL_0:   prdata = {8'd0, r_pal[0]};
            sbc_pkg::REG_PAL_1:   prdata = {8'd0, r_pal[1]};
            sbc_pkg::REG_PAL_2:   prdata = {8'd0, r_pal[2]};
            sbc_pkg::REG_PAL_3:   prdata = {8'd0, r_pal[3]};
            default:              prdata = 32'd0;
        endcase
    end

    assign o_frame_w = r_frame_w;
    assign o_frame_h = r_frame_h;
    assign o_pal     = r_pal;

endmodule

[src/sbc_ctrl.sv]
// controller fsm: sequences pixel, read and clear commands
`timescale 1ns / 1ps
module sbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_command,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sbc_pkg::t_dp_stat i_stat,
    output sbc_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MUL   = 5'b00100,
        S_ADDR  = 5'b01000,
        S_UPD   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;
    logic   emit;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        emit         = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    unique case (sbc_pkg::t_command'(i_command))
                        sbc_pkg::CMD_PIXEL: n_state = S_MUL;
                        sbc_pkg::CMD_READ:  n_state = S_MUL;
                        sbc_pkg::CMD_CLEAR: n_state = S_CLEAR;
                        sbc_pkg::CMD_NONE:  n_state = S_IDLE;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.calc = 1'b1;
                n_state    = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                // hold here while the previous word is still unread
                if (!i_stat.needs_result || slot_free) begin
                    o_cmd.update = 1'b1;
                    emit         = i_stat.needs_result;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == S_CLEAR)
        else $error("reset does not start the clearing pass");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites a word not yet taken");

    a_mul_to_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |=> r_state == S_ADDR)
        else $error("multiply stage not followed by address stage");

    a_update_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> (r_state == S_IDLE && !o_cmd.capture) || r_state == S_IDLE)
        else $error("update not followed by idle");

endmodule

[src/sbc_dp.sv]
// datapath: coordinates, frame store, collision count and palette lookup
`timescale 1ns / 1ps
module sbc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sbc_pkg::t_dp_cmd             i_cmd,
    output sbc_pkg::t_dp_stat            o_stat,
    input  logic [1:0]                   i_command,
    input  logic [7:0]                   i_pixel_value,
    input  logic                         i_text_mode,
    input  logic signed [9:0]            i_origin_x,
    input  logic signed [9:0]            i_origin_y,
    input  logic [8:0]                   i_sprite_width,
    input  logic [15:0]                  i_owner_tag,
    input  logic                         i_last_pixel,
    input  logic [15:0]                  i_read_index,
    input  logic [8:0]                   i_frame_w,
    input  logic [8:0]                   i_frame_h,
    input  logic [23:0]                  i_pal [4],
    output logic                         o_result_kind,
    output logic [sbc_pkg::HIT_W-1:0]    o_hit_count,
    output logic [7:0]                   o_red,
    output logic [7:0]                   o_green,
    output logic [7:0]                   o_blue
);

    localparam int AW = sbc_pkg::ADDR_W;
    localparam int OW = sbc_pkg::OWNER_BITS;
    localparam int HW = sbc_pkg::HIT_W;

    // captured word
    logic                 r_is_read;
    logic [1:0]           r_pix;
    logic [9:0]           r_ox;
    logic [9:0]           r_oy;
    logic [8:0]           r_sw;
    logic [OW-1:0]        r_owner;
    logic                 r_last;
    logic [15:0]          r_ri;
    // blit progress
    logic [7:0]           r_col, n_col;
    logic [7:0]           r_row, n_row;
    logic [sbc_pkg::HIT_W-1:0] r_hit, n_hit;
    logic [AW-1:0]        r_clr_ptr;
    // pipeline
    logic                 r_vis;
    logic [7:0]           r_xx;
    logic [16:0]          r_prod;
    logic [AW-1:0]        r_idx;
    logic                 r_inr;
    // result word
    logic                 r_res_kind;
    logic [sbc_pkg::HIT_W-1:0] r_res_hit;
    logic [23:0]          r_res_rgb;

    logic [8:0]           fw, fh;
    logic [1:0]           dec_pix;
    logic [10:0]          xx, yy;
    logic                 vis;
    logic [8:0]           mul_a;
    logic [AW-1:0]        idx;
    logic [AW-1:0]        ram_addr;
    logic                 ram_we;
    logic [sbc_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [OW-1:0]        old_owner;
    logic [1:0]           old_pix;
    logic [8:0]           col_inc;
    logic [1:0]           rd_pix;

    assign fw = sbc_pkg::clamp9(i_frame_w, sbc_pkg::FRAME_W_MAX);
    assign fh = sbc_pkg::clamp9(i_frame_h, sbc_pkg::FRAME_H_MAX);

    // decode the source byte, anything outside the drawable set is transparent
    always_comb begin
        dec_pix = 2'd0;
        if (i_text_mode) begin
            if (i_pixel_value >= sbc_pkg::CHAR_ONE && i_pixel_value <= sbc_pkg::CHAR_THREE)
                dec_pix = 2'(i_pixel_value - sbc_pkg::CHAR_ZERO);
        end else if (i_pixel_value != 8'd0 && i_pixel_value <= sbc_pkg::RAW_THREE) begin
            dec_pix = i_pixel_value[1:0];
        end
    end

    assign xx    = {r_ox[9], r_ox} + {3'd0, r_col};
    assign yy    = {r_oy[9], r_oy} + {3'd0, r_row};
    assign vis   = (r_pix != 2'd0) && !xx[10] && !yy[10]
                 && (xx[9:0] < {1'b0, fw}) && (yy[9:0] < {1'b0, fh});
    assign mul_a = r_is_read ? fh : {1'b0, yy[7:0]};
    assign idx   = r_is_read ? r_ri[AW-1:0] : AW'(r_prod + {9'd0, r_xx});

    always_comb begin
        ram_addr  = r_idx;
        ram_we    = 1'b0;
        ram_wdata = {r_owner, r_pix};
        if (i_cmd.clr_step) begin
            ram_addr  = r_clr_ptr;
            ram_we    = 1'b1;
            ram_wdata = '0;
        end else if (i_cmd.addr) begin
            ram_addr = idx;
        end else if (i_cmd.update && !r_is_read && r_vis) begin
            ram_we = 1'b1;
        end
    end

    sbc_ram #(
        .WIDTH(sbc_pkg::ENTRY_W),
        .DEPTH(sbc_pkg::FRAME_DEPTH)
    ) u_frame (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign old_owner = ram_rdata[sbc_pkg::ENTRY_W-1:sbc_pkg::PIX_W];
    assign old_pix   = ram_rdata[sbc_pkg::PIX_W-1:0];
    assign rd_pix    = r_inr ? old_pix : 2'd0;
    assign col_inc   = {1'b0, r_col} + 9'd1;

    // column, row and collision count after this pixel
    always_comb begin
        n_hit = r_hit;
        n_col = r_col;
        n_row = r_row;
        if (r_vis && old_owner != '0 && old_owner != r_owner && r_hit != sbc_pkg::HIT_MAX)
            n_hit = r_hit + HW'(1);
        if (col_inc >= r_sw) begin
            n_col = 8'd0;
            n_row = r_row + 8'd1;
        end else begin
            n_col = col_inc[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_hit     <= '0;
            r_clr_ptr <= '0;
            r_is_read <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_is_read <= (sbc_pkg::t_command'(i_command) == sbc_pkg::CMD_READ);
                r_last    <= i_last_pixel;
            end
            if (i_cmd.clr_step) r_clr_ptr <= r_clr_ptr + AW'(1);
            if (i_cmd.update && !r_is_read) begin
                if (r_last) begin
                    r_col <= '0;
                    r_row <= '0;
                    r_hit <= '0;
                end else begin
                    r_col <= n_col;
                    r_row <= n_row;
                    r_hit <= n_hit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix   <= dec_pix;
            r_ox    <= i_origin_x;
            r_oy    <= i_origin_y;
            r_sw    <= sbc_pkg::clamp9(i_sprite_width, sbc_pkg::SPRITE_W_MAX);
            r_owner <= i_owner_tag[OW-1:0];
            r_ri    <= i_read_index;
        end
        if (i_cmd.calc) begin
            r_vis  <= vis;
            r_xx   <= xx[7:0];
            r_prod <= {8'd0, mul_a} * {8'd0, fw};
        end
        if (i_cmd.addr) begin
            r_idx <= idx;
            r_inr <= {1'b0, r_ri} < r_prod;
        end
        if (i_cmd.update && o_stat.needs_result) begin
            r_res_kind <= r_is_read ? sbc_pkg::RESULT_READ : sbc_pkg::RESULT_BLIT;
            r_res_hit  <= r_is_read ? '0 : n_hit;
            r_res_rgb  <= r_is_read ? i_pal[rd_pix] : 24'd0;
        end
    end

    assign o_stat.clr_done     = (r_clr_ptr == '1);
    assign o_stat.needs_result = r_is_read || r_last;

    assign o_result_kind = r_res_kind;
    assign o_hit_count   = r_res_hit;
    assign o_red         = r_res_rgb[23:16];
    assign o_green       = r_res_rgb[15:8];
    assign o_blue        = r_res_rgb[7:0];

endmodule

[src/sprite_blitter_with_collision_count.sv]
// top level of the sprite blitter with collision count
//
//   channel   valid          ready          payload
//   input     i_in_valid     o_in_ready     i_command .. i_read_index
//   result    o_out_valid    i_out_ready    o_result_kind .. o_blue
//   config    psel/penable   pready (high)  paddr, pwdata, prdata
//
// a pixel or read word goes through accept, multiply for the frame address
// (or frame size for a read), frame ram read, read-modify-write and result.
// a clear word walks the frame ram one entry a cycle, over every entry.
// after reset the same clearing pass runs before the first word is taken.
// a finished result waits in the output register; the next word is still
// taken, and only a second result waits for the first to be taken.
`timescale 1ns / 1ps
module sprite_blitter_with_collision_count (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_command,
    input  logic [7:0]                 i_pixel_value,
    input  logic                       i_text_mode,
    input  logic signed [9:0]          i_origin_x,
    input  logic signed [9:0]          i_origin_y,
    input  logic [8:0]                 i_sprite_width,
    input  logic [15:0]                i_owner_tag,
    input  logic                       i_last_pixel,
    input  logic [15:0]                i_read_index,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_result_kind,
    output logic [16:0]                o_hit_count,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sbc_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    sbc_pkg::t_dp_cmd  dp_cmd;
    sbc_pkg::t_dp_stat dp_stat;
    logic [8:0]        frame_w;
    logic [8:0]        frame_h;
    logic [23:0]       pal [4];

    sbc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_frame_w(frame_w),
        .o_frame_h(frame_h),
        .o_pal    (pal)
    );

    sbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sbc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_command     (i_command),
        .i_pixel_value (i_pixel_value),
        .i_text_mode   (i_text_mode),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_sprite_width(i_sprite_width),
        .i_owner_tag   (i_owner_tag),
        .i_last_pixel  (i_last_pixel),
        .i_read_index  (i_read_index),
        .i_frame_w     (frame_w),
        .i_frame_h     (frame_h),
        .i_pal         (pal),
        .o_result_kind (o_result_kind),
        .o_hit_count   (o_hit_count),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue)
    );

endmodule
